// ----- rtl/quantized_channel_scale_clamp_macros.svh -----
// ----------------------------------------------------------------------------
// quantized_channel_scale_clamp assertion macros
// Shared concurrent assertion forms for the channel scale and clamp block.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_CHANNEL_SCALE_CLAMP_MACROS_SVH
`define QUANTIZED_CHANNEL_SCALE_CLAMP_MACROS_SVH

// same-cycle implication
`define QCSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QCSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/qcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// qcsc_pkg
// Types and constants shared by the channel scale and clamp block.
// ----------------------------------------------------------------------------
package qcsc_pkg;

    localparam int DEF_MAX_CHANNELS = 1024;
    localparam int DEF_MAX_SPATIAL  = 1048576;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LAYOUT_MINOR = 3'd0,
        CFG_CHANNELS     = 3'd1,
        CFG_SPATIAL      = 3'd2,
        CFG_SRC_BYTE     = 3'd3,
        CFG_RES_BYTE     = 3'd4,
        CFG_CLAMP_LOW    = 3'd5,
        CFG_CLAMP_HIGH   = 3'd6
    } t_cfg_index;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [9:0]         entry_channel;
        logic signed [31:0] entry_gain;
        logic signed [31:0] entry_offset;
        logic signed [31:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [9:0]         result_channel;
        logic               last_of_tensor;
    } t_out_word;

    // data word handed from the sequencer to the arithmetic pipeline
    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic [9:0]         channel;
        logic               last;
    } t_issue;

    // result formatting controls
    typedef struct packed {
        logic       result_is_byte;
        logic [7:0] clamp_low;
        logic [7:0] clamp_high;
    } t_res_cfg;

endpackage

// ----- rtl/qcsc_ram.sv -----
// ----------------------------------------------------------------------------
// qcsc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module qcsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/qcsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// qcsc_ctrl
// Configuration registers, tensor position counters and coefficient access.
// ----------------------------------------------------------------------------
`include "quantized_channel_scale_clamp_macros.svh"

module qcsc_ctrl #(
    parameter int MAX_CHANNELS = 1024,
    parameter int MAX_SPATIAL  = 1048576,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [qcsc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [qcsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  qcsc_pkg::t_in_word                  i_word,
    output logic                                o_ram_we,
    output logic [CH_W-1:0]                     o_ram_waddr,
    output logic [63:0]                         o_ram_wdata,
    output logic [CH_W-1:0]                     o_ram_raddr,
    output qcsc_pkg::t_issue                    o_issue,
    output qcsc_pkg::t_res_cfg                  o_res_cfg
);
    import qcsc_pkg::*;

    localparam int SP_W  = (MAX_SPATIAL > 1) ? $clog2(MAX_SPATIAL) : 1;
    localparam int CW    = ($clog2(MAX_CHANNELS + 1) > 11) ? $clog2(MAX_CHANNELS + 1) : 11;
    localparam int SW    = ($clog2(MAX_SPATIAL + 1) > 21) ? $clog2(MAX_SPATIAL + 1) : 21;
    localparam int EW    = (CH_W > 10) ? CH_W : 10;
    localparam int CXW   = (CH_W > 10) ? CH_W : 10;

    logic             r_layout_minor;
    logic [10:0]      r_channels;
    logic [20:0]      r_spatial;
    logic             r_src_byte;
    logic             r_res_byte;
    logic [7:0]       r_clamp_low;
    logic [7:0]       r_clamp_high;

    logic [CH_W-1:0]  r_chan_pos;
    logic [CH_W-1:0]  n_chan_pos;
    logic [SP_W-1:0]  r_spat_pos;
    logic [SP_W-1:0]  n_spat_pos;

    logic [CW-1:0]    chans_cfg;
    logic [CW-1:0]    chans_eff;
    logic [CW-1:0]    chan_last;
    logic [SW-1:0]    spat_cfg;
    logic [SW-1:0]    spat_eff;
    logic [SW-1:0]    spat_last;
    logic             chan_end;
    logic             spat_end;
    logic             is_data;
    logic [EW-1:0]    entry_ext;
    logic [CXW-1:0]   chan_ext;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_minor <= 1'b0;
            r_channels     <= 11'd1;
            r_spatial      <= 21'd1;
            r_src_byte     <= 1'b1;
            r_res_byte     <= 1'b1;
            r_clamp_low    <= 8'd0;
            r_clamp_high   <= 8'd255;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LAYOUT_MINOR: r_layout_minor <= i_cfg_data[0];
                CFG_CHANNELS:     r_channels     <= i_cfg_data[10:0];
                CFG_SPATIAL:      r_spatial      <= i_cfg_data[20:0];
                CFG_SRC_BYTE:     r_src_byte     <= i_cfg_data[0];
                CFG_RES_BYTE:     r_res_byte     <= i_cfg_data[0];
                CFG_CLAMP_LOW:    r_clamp_low    <= i_cfg_data[7:0];
                CFG_CLAMP_HIGH:   r_clamp_high   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // effective limits
    always_comb begin
        chans_cfg = CW'(r_channels);
        chans_eff = (chans_cfg == '0) ? CW'(1) : chans_cfg;
        if (chans_eff > CW'(MAX_CHANNELS)) begin
            chans_eff = CW'(MAX_CHANNELS);
        end
        chan_last = chans_eff - CW'(1);

        spat_cfg = SW'(r_spatial);
        spat_eff = (spat_cfg == '0) ? SW'(1) : spat_cfg;
        if (spat_eff > SW'(MAX_SPATIAL)) begin
            spat_eff = SW'(MAX_SPATIAL);
        end
        spat_last = spat_eff - SW'(1);

        chan_end = CW'(r_chan_pos) >= chan_last;
        spat_end = SW'(r_spat_pos) >= spat_last;
    end

    assign is_data = (i_word.mode == MODE_DATA);

    // position advance
    always_comb begin
        n_chan_pos = r_chan_pos;
        n_spat_pos = r_spat_pos;
        if (i_accept) begin
            if (!is_data) begin
                n_chan_pos = '0;
                n_spat_pos = '0;
            end else if (r_layout_minor) begin
                if (chan_end) begin
                    n_chan_pos = '0;
                    n_spat_pos = spat_end ? '0 : r_spat_pos + SP_W'(1);
                end else begin
                    n_chan_pos = r_chan_pos + CH_W'(1);
                end
            end else begin
                if (spat_end) begin
                    n_spat_pos = '0;
                    n_chan_pos = chan_end ? '0 : r_chan_pos + CH_W'(1);
                end else begin
                    n_spat_pos = r_spat_pos + SP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_pos <= '0;
            r_spat_pos <= '0;
        end else begin
            r_chan_pos <= n_chan_pos;
            r_spat_pos <= n_spat_pos;
        end
    end

    // coefficient table access
    assign entry_ext   = EW'(i_word.entry_channel);
    assign o_ram_we    = i_accept && !is_data && (32'(i_word.entry_channel) < 32'(MAX_CHANNELS));
    assign o_ram_waddr = entry_ext[CH_W-1:0];
    assign o_ram_wdata = {i_word.entry_gain, i_word.entry_offset};
    assign o_ram_raddr = r_chan_pos;

    // issue word
    assign chan_ext        = CXW'(r_chan_pos);
    assign o_issue.valid   = i_accept && is_data;
    assign o_issue.x       = r_src_byte ? {8'd0, i_word.sample[7:0], 16'd0} : i_word.sample;
    assign o_issue.channel = chan_ext[9:0];
    assign o_issue.last    = chan_end && spat_end;

    assign o_res_cfg.result_is_byte = r_res_byte;
    assign o_res_cfg.clamp_low      = r_clamp_low;
    assign o_res_cfg.clamp_high     = r_clamp_high;

    `QCSC_ASSERT_IMPL(a_chan_pos_in_table, i_clk, i_rst_n, 1'b1,
        32'(r_chan_pos) < 32'(MAX_CHANNELS), "channel position beyond table")
    `QCSC_ASSERT_NEXT(a_load_restarts, i_clk, i_rst_n, i_accept && !is_data,
        r_chan_pos == '0 && r_spat_pos == '0, "load did not restart positions")
    `QCSC_ASSERT_IMPL(a_write_not_issue, i_clk, i_rst_n, o_ram_we,
        !o_issue.valid, "table write together with data issue")

endmodule

// ----- rtl/qcsc_datapath.sv -----
// ----------------------------------------------------------------------------
// qcsc_datapath
// Multiply-add pipeline with rounding, clamping and saturation.
// ----------------------------------------------------------------------------
module qcsc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  qcsc_pkg::t_issue      i_issue,
    input  logic [63:0]           i_coef,
    input  qcsc_pkg::t_res_cfg    i_res_cfg,
    output logic                  o_valid,
    output qcsc_pkg::t_out_word   o_word
);
    import qcsc_pkg::*;

    // stage 1: aligned with table read data
    logic               r1_valid;
    logic signed [31:0] r1_x;
    logic [9:0]         r1_chan;
    logic               r1_last;
    // stage 2: product
    logic               r2_valid;
    logic signed [63:0] r2_prod;
    logic signed [31:0] r2_offset;
    logic [9:0]         r2_chan;
    logic               r2_last;
    // stage 3: accumulator
    logic               r3_valid;
    logic signed [63:0] r3_acc;
    logic [9:0]         r3_chan;
    logic               r3_last;
    // stage 4: rounding bias added
    logic               r4_valid;
    logic signed [63:0] r4_rnd;
    logic [9:0]         r4_chan;
    logic               r4_last;
    // output
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic signed [31:0] gain;
    logic signed [31:0] offset;
    logic signed [63:0] n_prod;
    logic signed [63:0] n_acc;
    logic signed [63:0] n_rnd;
    logic signed [63:0] half;
    logic signed [31:0] n_value;
    logic signed [31:0] byte_val;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [47:0] q_val;

    assign gain   = i_coef[63:32];
    assign offset = i_coef[31:0];

    assign n_prod = $signed(r1_x) * $signed(gain);
    assign n_acc  = r2_prod + {{16{r2_offset[31]}}, r2_offset, 16'd0};
    assign half   = i_res_cfg.result_is_byte ? 64'sh0000_0000_8000_0000
                                             : 64'sh0000_0000_0000_8000;
    // ties away from zero: bias by half, one less for negative values
    assign n_rnd  = r3_acc + half - 64'(r3_acc[63]);

    always_comb begin
        byte_val = r4_rnd[63:32];
        lo       = {24'd0, i_res_cfg.clamp_low};
        hi       = {24'd0, i_res_cfg.clamp_high};
        q_val    = r4_rnd[63:16];
        if (i_res_cfg.result_is_byte) begin
            n_value = byte_val;
            if (n_value < lo) begin
                n_value = lo;
            end
            if (n_value > hi) begin
                n_value = hi;
            end
        end else if (q_val[47] && !(&q_val[47:31])) begin
            n_value = 32'sh8000_0000;
        end else if (!q_val[47] && (|q_val[47:31])) begin
            n_value = 32'sh7FFF_FFFF;
        end else begin
            n_value = q_val[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid    <= i_issue.valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x      <= i_issue.x;
            r1_chan   <= i_issue.channel;
            r1_last   <= i_issue.last;

            r2_prod   <= n_prod;
            r2_offset <= offset;
            r2_chan   <= r1_chan;
            r2_last   <= r1_last;

            r3_acc    <= n_acc;
            r3_chan   <= r2_chan;
            r3_last   <= r2_last;

            r4_rnd    <= n_rnd;
            r4_chan   <= r3_chan;
            r4_last   <= r3_last;

            r_out_word.result_value   <= n_value;
            r_out_word.result_channel <= r4_chan;
            r_out_word.last_of_tensor <= r4_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

// ----- rtl/quantized_channel_scale_clamp.sv -----
// ----------------------------------------------------------------------------
// quantized_channel_scale_clamp
// Per-channel requantizing scale and shift over a streamed tensor.
// ----------------------------------------------------------------------------
// Takes one word per clock unless stalled, gives one result per data word
// and none for load words. The coefficient table is one RAM with a single
// registered read port, read whenever the pipeline is not held, and the
// multiply, accumulate, round and clamp each have a pipeline stage of their
// own. A stall on the output holds the whole pipeline and is passed to the
// input in the same cycle. The table has no reset and no clearing pass: load
// every channel in use before streaming data. Configuration writes are
// always ready; the user, not the block, keeps them to idle periods.
`include "quantized_channel_scale_clamp_macros.svh"

module quantized_channel_scale_clamp #(
    parameter int MAX_CHANNELS = qcsc_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_SPATIAL  = qcsc_pkg::DEF_MAX_SPATIAL
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  qcsc_pkg::t_in_word               i_word,
    output logic                             o_valid,
    input  logic                             i_stall,
    output qcsc_pkg::t_out_word              o_word,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [qcsc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [qcsc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import qcsc_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic             en;
    logic             accept;
    logic             ram_we;
    logic [CH_W-1:0]  ram_waddr;
    logic [63:0]      ram_wdata;
    logic [CH_W-1:0]  ram_raddr;
    logic [63:0]      ram_rdata;
    t_issue           issue;
    t_res_cfg         res_cfg;

    assign o_stall     = o_valid && i_stall;
    assign en          = !o_stall;
    assign accept      = i_valid && en;
    assign o_cfg_ready = 1'b1;

    qcsc_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SPATIAL  (MAX_SPATIAL),
        .CH_W         (CH_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_word      (i_word),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .o_issue     (issue),
        .o_res_cfg   (res_cfg)
    );

    qcsc_ram #(
        .WIDTH (64),
        .DEPTH (MAX_CHANNELS),
        .AW    (CH_W)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    qcsc_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_issue   (issue),
        .i_coef    (ram_rdata),
        .i_res_cfg (res_cfg),
        .o_valid   (o_valid),
        .o_word    (o_word)
    );

    `QCSC_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid,
        "input stalled while output register empty")
    `QCSC_ASSERT_NEXT(a_stalled_result_kept, i_clk, i_rst_n, o_valid && i_stall,
        o_valid, "pending result dropped under stall")
    `QCSC_ASSERT_IMPL(a_no_accept_on_stall, i_clk, i_rst_n, o_stall, !accept,
        "word accepted while pipeline held")

endmodule
